// ----- design/tcp_pkg.sv -----
// Shared types, constants and helpers for the triad coupling pair block.
package tcp_pkg;

  localparam int IDX_W  = 12;
  localparam int WAVE_W = 5;
  localparam int VEL_W  = 64;
  localparam int OUT_W  = 64;

  // Command codes of an input request.
  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_e;

  // One entry of the mode table.
  typedef struct packed {
    logic signed [WAVE_W-1:0] wz;
    logic signed [WAVE_W-1:0] wy;
    logic signed [WAVE_W-1:0] wx;
    logic [VEL_W-1:0]         vx;
    logic [VEL_W-1:0]         vy;
    logic [VEL_W-1:0]         vz;
  } mode_t;

  // Clamp a wavevector component to [-lim, lim].
  function automatic logic signed [WAVE_W-1:0] clamp_wave(
    input logic signed [WAVE_W-1:0] w,
    input logic signed [7:0]        lim
  );
    logic signed [7:0] e;
    e = 8'(w);
    if (e > lim) begin
      clamp_wave = WAVE_W'(lim);
    end else if (e < -lim) begin
      clamp_wave = WAVE_W'(-lim);
    end else begin
      clamp_wave = w;
    end
  endfunction

endpackage

// ----- design/triad_coupling_pair.sv -----
// Top level: mode table, fetch stage, two coupling lanes and the result register.
//
//  Channel   Ports                                         Handshake
//  request   command_i, k_index_i, wave_*_i, vel_*_i,      start high, busy low
//            p_index_i, q_index_i
//  result    coupling_pq_o, coupling_qp_o, opposite_sign_o strobe_o for one cycle
//
// A request is taken in every cycle; busy never rises. A load writes the table at
// the edge that accepts it, so a compute in the next cycle already sees it.
// A compute passes through the table read at the edge that accepts it, 17 register stages
// of the lane (8 of them the divider by |k|^2, 8 bits each) and the output register.
// Reset clears only the valid bits; the table is not cleared.
module triad_coupling_pair import tcp_pkg::*; #(
  parameter int MODE_DEPTH = 4096,
  parameter int MAX_WAVE   = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     command_i,
  input  logic [IDX_W-1:0]         k_index_i,
  input  logic signed [WAVE_W-1:0] wave_x_i,
  input  logic signed [WAVE_W-1:0] wave_y_i,
  input  logic signed [WAVE_W-1:0] wave_z_i,
  input  logic [VEL_W-1:0]         vel_x_i,
  input  logic [VEL_W-1:0]         vel_y_i,
  input  logic [VEL_W-1:0]         vel_z_i,
  input  logic [IDX_W-1:0]         p_index_i,
  input  logic [IDX_W-1:0]         q_index_i,
  output logic                     strobe_o,
  output logic signed [OUT_W-1:0]  coupling_pq_o,
  output logic signed [OUT_W-1:0]  coupling_qp_o,
  output logic                     opposite_sign_o
);

  localparam int AW = $clog2(MODE_DEPTH);

  logic accept, do_load, do_comp;
  logic k_ok, p_ok, q_ok;
  logic [AW-1:0] k_addr, p_addr, q_addr;
  mode_t wr_ent;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign do_load = accept && (cmd_e'(command_i) == CMD_LOAD);
  assign do_comp = accept && (cmd_e'(command_i) == CMD_COMPUTE);

  assign k_ok   = (32'(k_index_i) < 32'(MODE_DEPTH));
  assign p_ok   = (32'(p_index_i) < 32'(MODE_DEPTH));
  assign q_ok   = (32'(q_index_i) < 32'(MODE_DEPTH));
  assign k_addr = AW'(k_index_i);
  assign p_addr = AW'(p_index_i);
  assign q_addr = AW'(q_index_i);

  // Entry written on load, with clamped wavevector.
  always_comb begin
    wr_ent.wx = clamp_wave(wave_x_i, $signed(8'(MAX_WAVE)));
    wr_ent.wy = clamp_wave(wave_y_i, $signed(8'(MAX_WAVE)));
    wr_ent.wz = clamp_wave(wave_z_i, $signed(8'(MAX_WAVE)));
    wr_ent.vx = vel_x_i;
    wr_ent.vy = vel_y_i;
    wr_ent.vz = vel_z_i;
  end

  // Two copies of the table: one serves k and p, the other q.
  mode_t mem_a_q [MODE_DEPTH];
  mode_t mem_b_q [MODE_DEPTH];
  mode_t rk_q, rp_q, rq_q;

  always_ff @(posedge clk_i) begin
    if (do_load && k_ok) begin
      mem_a_q[k_addr] <= wr_ent;
      mem_b_q[k_addr] <= wr_ent;
    end
    rk_q <= mem_a_q[k_addr];
    rp_q <= mem_a_q[p_addr];
    rq_q <= mem_b_q[q_addr];
  end

  // Fetch stage control: valid and in-range flags.
  logic rv_q, rk_ok_q, rp_ok_q, rq_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= do_comp;
    end
  end

  always_ff @(posedge clk_i) begin
    rk_ok_q <= k_ok;
    rp_ok_q <= p_ok;
    rq_ok_q <= q_ok;
  end

  // An index beyond the table reads as an all-zero mode.
  mode_t k_ent, p_ent, q_ent;
  assign k_ent = rk_ok_q ? rk_q : '0;
  assign p_ent = rp_ok_q ? rp_q : '0;
  assign q_ent = rq_ok_q ? rq_q : '0;

  // Lanes for c(p,q) and c(q,p).
  logic                    pq_valid, qp_valid;
  logic signed [OUT_W-1:0] pq_val, qp_val;

  tcp_couple u_lane_pq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (rv_q),
    .k_i        (k_ent),
    .p_i        (p_ent),
    .q_i        (q_ent),
    .valid_o    (pq_valid),
    .coupling_o (pq_val)
  );

  tcp_couple u_lane_qp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (rv_q),
    .k_i        (k_ent),
    .p_i        (q_ent),
    .q_i        (p_ent),
    .valid_o    (qp_valid),
    .coupling_o (qp_val)
  );

  // Result register with the opposite-sign flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= pq_valid && qp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    coupling_pq_o   <= pq_val;
    coupling_qp_o   <= qp_val;
    opposite_sign_o <= ((pq_val < 0) && (qp_val > 0)) || ((pq_val > 0) && (qp_val < 0));
  end

endmodule

// ----- design/tcp_couple.sv -----
// Pipelined datapath computing one triad coupling c(p,q) from three fetched modes.
module tcp_couple import tcp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  mode_t                   k_i,
  input  mode_t                   p_i,
  input  mode_t                   q_i,
  output logic                    valid_o,
  output logic signed [OUT_W-1:0] coupling_o
);

  localparam int AB_W     = 39;
  localparam int K2_W     = 10;
  localparam int WR_W     = 46;
  localparam int WL_W     = 23;
  localparam int PH_W     = 57;
  localparam int PR_W     = 78;
  localparam int V_W      = 82;
  localparam int PP_W     = 68;
  localparam int S_W      = 122;
  localparam int M_W      = S_W - 32;
  localparam int Q_W      = 64;
  localparam int DIV_STEP = 8;
  localparam int DIV_STG  = Q_W / DIV_STEP;

  // Unpack the three modes into components.
  logic [VEL_W-1:0]         kv [3];
  logic [VEL_W-1:0]         pv [3];
  logic [VEL_W-1:0]         qv [3];
  logic signed [WAVE_W-1:0] kw [3];
  logic signed [WAVE_W-1:0] qw [3];
  assign kv = '{k_i.vx, k_i.vy, k_i.vz};
  assign pv = '{p_i.vx, p_i.vy, p_i.vz};
  assign qv = '{q_i.vx, q_i.vy, q_i.vz};
  assign kw = '{k_i.wx, k_i.wy, k_i.wz};
  assign qw = '{q_i.wx, q_i.wy, q_i.wz};

  // Stage 1: dot products with wavevectors and |k|^2.
  logic                   v1_q;
  logic signed [AB_W-1:0] a1_q, b1_q, kdr1_q, kdi1_q;
  logic [K2_W-1:0]        k21_q;
  logic signed [WAVE_W-1:0] kw1_q [3];
  logic signed [31:0]     kre1_q [3], kim1_q [3], qre1_q [3], qim1_q [3];
  logic signed [AB_W-1:0] a_d, b_d, kdr_d, kdi_d;
  logic signed [11:0]     k2s_d;

  always_comb begin
    a_d = '0; b_d = '0; kdr_d = '0; kdi_d = '0; k2s_d = '0;
    for (int c = 0; c < 3; c++) begin
      a_d   = a_d + AB_W'($signed(pv[c][63:32])) * AB_W'(qw[c]);
      b_d   = b_d + AB_W'($signed(pv[c][31:0])) * AB_W'(qw[c]);
      kdr_d = kdr_d + AB_W'(kw[c]) * AB_W'($signed(qv[c][63:32]));
      kdi_d = kdi_d + AB_W'(kw[c]) * AB_W'($signed(qv[c][31:0]));
      k2s_d = k2s_d + 12'(kw[c]) * 12'(kw[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q   <= a_d;
    b1_q   <= b_d;
    kdr1_q <= kdr_d;
    kdi1_q <= kdi_d;
    k21_q  <= K2_W'(k2s_d);
    for (int c = 0; c < 3; c++) begin
      kw1_q[c]  <= kw[c];
      kre1_q[c] <= $signed(kv[c][63:32]);
      kim1_q[c] <= $signed(kv[c][31:0]);
      qre1_q[c] <= $signed(qv[c][63:32]);
      qim1_q[c] <= $signed(qv[c][31:0]);
    end
  end

  // Stage 2: projection of u_q perpendicular to k, scaled by |k|^2.
  logic                   v2_q;
  logic signed [AB_W-1:0] a2_q, b2_q;
  logic [K2_W-1:0]        k22_q;
  logic signed [31:0]     kre2_q [3], kim2_q [3];
  logic signed [WR_W-1:0] wr2_q [3], wi2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a2_q  <= a1_q;
    b2_q  <= b1_q;
    k22_q <= k21_q;
    for (int c = 0; c < 3; c++) begin
      kre2_q[c] <= kre1_q[c];
      kim2_q[c] <= kim1_q[c];
      wr2_q[c]  <= WR_W'($signed({1'b0, k21_q})) * WR_W'(qre1_q[c])
                 - WR_W'(kdr1_q) * WR_W'(kw1_q[c]);
      wi2_q[c]  <= WR_W'($signed({1'b0, k21_q})) * WR_W'(qim1_q[c])
                 - WR_W'(kdi1_q) * WR_W'(kw1_q[c]);
    end
  end

  // Stage 3: partial products of conj(u_k) with the projection, cut in two halves.
  logic                   v3_q;
  logic signed [AB_W-1:0] a3_q, b3_q;
  logic [K2_W-1:0]        k23_q;
  logic signed [PH_W-1:0] rrl3_q [3], rrh3_q [3], iil3_q [3], iih3_q [3];
  logic signed [PH_W-1:0] ril3_q [3], rih3_q [3], irl3_q [3], irh3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a3_q  <= a2_q;
    b3_q  <= b2_q;
    k23_q <= k22_q;
    for (int c = 0; c < 3; c++) begin
      rrl3_q[c] <= PH_W'(kre2_q[c]) * PH_W'($signed({1'b0, wr2_q[c][WL_W-1:0]}));
      rrh3_q[c] <= PH_W'(kre2_q[c]) * PH_W'($signed(wr2_q[c][WR_W-1:WL_W]));
      iil3_q[c] <= PH_W'(kim2_q[c]) * PH_W'($signed({1'b0, wi2_q[c][WL_W-1:0]}));
      iih3_q[c] <= PH_W'(kim2_q[c]) * PH_W'($signed(wi2_q[c][WR_W-1:WL_W]));
      ril3_q[c] <= PH_W'(kre2_q[c]) * PH_W'($signed({1'b0, wi2_q[c][WL_W-1:0]}));
      rih3_q[c] <= PH_W'(kre2_q[c]) * PH_W'($signed(wi2_q[c][WR_W-1:WL_W]));
      irl3_q[c] <= PH_W'(kim2_q[c]) * PH_W'($signed({1'b0, wr2_q[c][WL_W-1:0]}));
      irh3_q[c] <= PH_W'(kim2_q[c]) * PH_W'($signed(wr2_q[c][WR_W-1:WL_W]));
    end
  end

  // Stage 3b: recombine the halves into the full products.
  logic                   v3b_q;
  logic signed [AB_W-1:0] a3b_q, b3b_q;
  logic [K2_W-1:0]        k23b_q;
  logic signed [PR_W-1:0] prr3_q [3], pii3_q [3], pri3_q [3], pir3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3b_q <= 1'b0;
    end else begin
      v3b_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a3b_q  <= a3_q;
    b3b_q  <= b3_q;
    k23b_q <= k23_q;
    for (int c = 0; c < 3; c++) begin
      prr3_q[c] <= (PR_W'(rrh3_q[c]) <<< WL_W) + PR_W'(rrl3_q[c]);
      pii3_q[c] <= (PR_W'(iih3_q[c]) <<< WL_W) + PR_W'(iil3_q[c]);
      pri3_q[c] <= (PR_W'(rih3_q[c]) <<< WL_W) + PR_W'(ril3_q[c]);
      pir3_q[c] <= (PR_W'(irh3_q[c]) <<< WL_W) + PR_W'(irl3_q[c]);
    end
  end

  // Stage 4: sum the components into vr and vi.
  logic                   v4_q;
  logic signed [AB_W-1:0] a4_q, b4_q;
  logic [K2_W-1:0]        k24_q;
  logic signed [V_W-1:0]  vr4_q, vi4_q;
  logic signed [V_W-1:0]  vr_d, vi_d;

  always_comb begin
    vr_d = '0;
    vi_d = '0;
    for (int c = 0; c < 3; c++) begin
      vr_d = vr_d + V_W'(prr3_q[c]) + V_W'(pii3_q[c]);
      vi_d = vi_d + V_W'(pri3_q[c]) - V_W'(pir3_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a4_q  <= a3b_q;
    b4_q  <= b3b_q;
    k24_q <= k23b_q;
    vr4_q <= vr_d;
    vi4_q <= vi_d;
  end

  // Stage 5: partial products of a*vi and b*vr, vi and vr cut in three.
  logic                   v5_q;
  logic [K2_W-1:0]        k25_q;
  logic signed [PP_W-1:0] pa5_q [3], pb5_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k25_q    <= k24_q;
    pa5_q[0] <= PP_W'(a4_q) * PP_W'($signed({1'b0, vi4_q[26:0]}));
    pa5_q[1] <= PP_W'(a4_q) * PP_W'($signed({1'b0, vi4_q[53:27]}));
    pa5_q[2] <= PP_W'(a4_q) * PP_W'($signed(vi4_q[V_W-1:54]));
    pb5_q[0] <= PP_W'(b4_q) * PP_W'($signed({1'b0, vr4_q[26:0]}));
    pb5_q[1] <= PP_W'(b4_q) * PP_W'($signed({1'b0, vr4_q[53:27]}));
    pb5_q[2] <= PP_W'(b4_q) * PP_W'($signed(vr4_q[V_W-1:54]));
  end

  // Stage 6: combine the partial products into the exact sum.
  logic                  v6_q;
  logic [K2_W-1:0]       k26_q;
  logic signed [S_W-1:0] s6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k26_q <= k25_q;
    s6_q  <= (S_W'(pa5_q[2]) <<< 54) + (S_W'(pa5_q[1]) <<< 27) + S_W'(pa5_q[0])
           + (S_W'(pb5_q[2]) <<< 54) + (S_W'(pb5_q[1]) <<< 27) + S_W'(pb5_q[0]);
  end

  // Stage 7: take the magnitude, drop 32 fraction bits, detect overflow and flag a zero |k|^2.
  logic             v7_q, neg7_q, ov7_q, zero7_q;
  logic [K2_W-1:0]  k27_q, rem7_q;
  logic [Q_W-1:0]   work7_q;
  logic [S_W-1:0]   mag_d;
  logic [M_W-1:0]   m_d;

  assign mag_d = s6_q[S_W-1] ? S_W'(-s6_q) : S_W'(s6_q);
  assign m_d   = mag_d[S_W-1:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k27_q   <= k26_q;
    neg7_q  <= s6_q[S_W-1];
    zero7_q <= (k26_q == '0);
    ov7_q   <= (m_d[M_W-1:Q_W-1] >= (M_W-Q_W+1)'(k26_q));
    rem7_q  <= m_d[Q_W+K2_W-1:Q_W];
    work7_q <= m_d[Q_W-1:0];
  end

  // Divider: restoring division by |k|^2, DIV_STEP quotient bits per stage.
  logic             dv_q   [DIV_STG];
  logic             dneg_q [DIV_STG];
  logic             dov_q  [DIV_STG];
  logic             dzero_q[DIV_STG];
  logic [K2_W-1:0]  dk2_q  [DIV_STG];
  logic [K2_W-1:0]  drem_q [DIV_STG];
  logic [Q_W-1:0]   dwork_q[DIV_STG];

  for (genvar st = 0; st < DIV_STG; st++) begin : g_div
    logic            v_in, neg_in, ov_in, zero_in;
    logic [K2_W-1:0] k2_in, rem_in, rem_d;
    logic [Q_W-1:0]  work_in, work_d;
    logic [K2_W:0]   t_d;

    if (st == 0) begin : g_first
      assign v_in    = v7_q;
      assign neg_in  = neg7_q;
      assign ov_in   = ov7_q;
      assign zero_in = zero7_q;
      assign k2_in   = k27_q;
      assign rem_in  = rem7_q;
      assign work_in = work7_q;
    end else begin : g_next
      assign v_in    = dv_q[st-1];
      assign neg_in  = dneg_q[st-1];
      assign ov_in   = dov_q[st-1];
      assign zero_in = dzero_q[st-1];
      assign k2_in   = dk2_q[st-1];
      assign rem_in  = drem_q[st-1];
      assign work_in = dwork_q[st-1];
    end

    // Shift in one dividend bit, subtract where it fits, shift in the quotient bit.
    always_comb begin
      rem_d  = rem_in;
      work_d = work_in;
      t_d    = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
        t_d    = {rem_d, work_d[Q_W-1]};
        work_d = {work_d[Q_W-2:0], 1'b0};
        if (t_d >= {1'b0, k2_in}) begin
          rem_d     = K2_W'(t_d - {1'b0, k2_in});
          work_d[0] = 1'b1;
        end else begin
          rem_d = t_d[K2_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[st] <= 1'b0;
      end else begin
        dv_q[st] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dneg_q[st]  <= neg_in;
      dov_q[st]   <= ov_in;
      dzero_q[st] <= zero_in;
      dk2_q[st]   <= k2_in;
      drem_q[st]  <= rem_d;
      dwork_q[st] <= work_d;
    end
  end

  // Final stage: sign, saturation and the zero-k case.
  logic signed [OUT_W-1:0] res_d;

  always_comb begin
    priority if (dzero_q[DIV_STG-1]) begin
      res_d = '0;
    end else if (dov_q[DIV_STG-1]) begin
      res_d = dneg_q[DIV_STG-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else if (dneg_q[DIV_STG-1]) begin
      res_d = -$signed(dwork_q[DIV_STG-1]);
    end else begin
      res_d = $signed(dwork_q[DIV_STG-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= dv_q[DIV_STG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    coupling_o <= res_d;
  end

endmodule
